>>> hw/rtl/stst_pkg.sv
`timescale 1ns / 1ps
// Package for the sorted time schedule table: sizes, codes, beat and command types.
// Used by stst_cell, sorted_time_schedule_table_top and the dv checker and testbench; depends on nothing else.
package stst_pkg;

   localparam int PIN_COUNT      = 8;
   localparam int EVENTS_PER_PIN = 16;
   localparam int HOUR_MINUTES   = 60;
   localparam int MONTH_DAYS     = 32;

   localparam int PIN_W  = (PIN_COUNT > 1) ? $clog2(PIN_COUNT) : 1;
   localparam int CNT_W  = $clog2(EVENTS_PER_PIN + 1);
   localparam int KEY_W  = 11;
   localparam int DATE_W = 9;

   typedef logic [PIN_W-1:0]  pin_type;
   typedef logic [CNT_W-1:0]  cnt_type;
   typedef logic [KEY_W-1:0]  key_type;
   typedef logic [DATE_W-1:0] date_type;

   typedef enum logic [1:0] {
      FUNC_INSERT = 2'd0,
      FUNC_REMOVE = 2'd1,
      FUNC_CLEAR  = 2'd2,
      FUNC_QUERY  = 2'd3
   } func_type;

   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_FULL = 2'd1;
   localparam logic [1:0] STATUS_MISS = 2'd2;

   typedef struct packed {
      logic [4:0] hour;
      logic [5:0] minute;
      logic [3:0] from_month;
      logic [4:0] from_day;
      logic [3:0] to_month;
      logic [4:0] to_day;
      logic [7:0] level;
   } entry_type;

   typedef struct packed {
      func_type  func;
      pin_type   pin;
      logic      pin_ok;
      logic      ins_ok;
      cnt_type   count;
      key_type   key;
      date_type  now_date;
      entry_type ev;
   } cmd_type;

   typedef struct packed {
      logic      act;
      logic      flag;
      cnt_type   idx;
      logic [7:0] lvl;
      entry_type carry;
   } beat_type;

   function automatic key_type time_key(input logic [4:0] hour, input logic [5:0] minute);
      return key_type'(hour) * key_type'(HOUR_MINUTES) + key_type'(minute);
   endfunction

   function automatic date_type date_key(input logic [3:0] month, input logic [4:0] day);
      return date_type'(month) * date_type'(MONTH_DAYS) + date_type'(day);
   endfunction

endpackage

>>> hw/rtl/stst_cell.sv
`timescale 1ns / 1ps
// One slot of the schedule chain: holds the entry at its position for every pin.
// Depends on stst_pkg; instanced in a row by sorted_time_schedule_table_top.
module stst_cell (
   input  logic                clock,
   input  logic                reset,
   input  stst_pkg::cnt_type   cell_idx,
   input  stst_pkg::cmd_type   cmd,
   input  stst_pkg::beat_type  beat_in,
   output stst_pkg::beat_type  beat_out,
   input  stst_pkg::entry_type right_entry,
   output stst_pkg::entry_type own_entry
);
   import stst_pkg::*;

   entry_type store_ff [PIN_COUNT];
   beat_type  beat_ff;
   beat_type  beat_in_next;
   logic      wr;
   entry_type wr_data;
   logic      valid;
   key_type   own_key;
   date_type  first_date;
   date_type  last_date;

   assign own_entry  = store_ff[cmd.pin];
   assign valid      = cell_idx < cmd.count;
   assign own_key    = time_key(own_entry.hour, own_entry.minute);
   assign first_date = date_key(own_entry.from_month, own_entry.from_day);
   assign last_date  = date_key(own_entry.to_month, own_entry.to_day);

   always_comb begin
      beat_in_next = beat_in;
      wr           = 1'b0;
      wr_data      = beat_in.carry;
      if (beat_in.act) begin
         unique case (cmd.func)
            FUNC_INSERT: begin
               if (cmd.ins_ok) begin
                  if (valid) begin
                     if (beat_in.flag || (own_key > cmd.key)) begin
                        wr                 = 1'b1;
                        beat_in_next.carry = own_entry;
                        beat_in_next.flag  = 1'b1;
                     end
                  end else if (cell_idx == cmd.count) begin
                     wr = 1'b1;
                  end
               end
            end
            FUNC_REMOVE: begin
               if (valid && (beat_in.flag || (own_entry == cmd.ev))) begin
                  wr                = 1'b1;
                  wr_data           = right_entry;
                  beat_in_next.flag = 1'b1;
               end
            end
            FUNC_CLEAR: begin
            end
            FUNC_QUERY: begin
               if (valid && !beat_in.flag && (own_key >= cmd.key) &&
                   (cmd.now_date >= first_date) && (cmd.now_date <= last_date)) begin
                  beat_in_next.flag = 1'b1;
                  beat_in_next.idx  = cell_idx;
                  beat_in_next.lvl  = own_entry.level;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (wr) begin
         store_ff[cmd.pin] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff <= '0;
      end else begin
         beat_ff <= beat_in_next;
      end
   end

   assign beat_out = beat_ff;

endmodule

>>> hw/rtl/sorted_time_schedule_table_top.sv
`timescale 1ns / 1ps
// Top level of the sorted time schedule table: command intake, per-pin counts, results.
// Depends on stst_pkg and stst_cell.
//
// Usage: drive the req_ fields and raise start; the beat is taken at the clock edge
// where start is high and busy is low. busy then stays high while the command walks
// the chain of EVENTS_PER_PIN slot cells, one cell per cycle. Each cell holds one
// table position for every pin and shifts entries to or from its neighbor as the
// command passes, so inserts, removes and searches keep the per-pin time order.
// The result appears on the rsp_ ports for exactly one cycle with rsp_valid high,
// after the command has passed launch_ff, the beat register of every cell and the
// rsp_ registers. busy drops in that same cycle, so a new command may be taken while
// the result shows, but not while one is still in the chain; the chain length sets this.
// The receiver cannot stall; a result that is not taken is lost.
// Reset clears every pin's event count and empties the chain; the stored entries
// need no clearing because only positions below a pin's count are ever read.
module sorted_time_schedule_table_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [1:0] req_func,
   input  logic [2:0] req_pin_index,
   input  logic [4:0] req_hour,
   input  logic [5:0] req_minute,
   input  logic [3:0] req_from_month,
   input  logic [4:0] req_from_day,
   input  logic [3:0] req_to_month,
   input  logic [4:0] req_to_day,
   input  logic [7:0] req_level,
   input  logic [3:0] req_now_month,
   input  logic [4:0] req_now_day,
   output logic       rsp_valid,
   output logic [1:0] rsp_status,
   output logic [4:0] rsp_next_index,
   output logic [4:0] rsp_entry_count,
   output logic [7:0] rsp_next_level
);
   import stst_pkg::*;

   logic      accept;
   logic      pin_ok;
   cnt_type   n_sel;
   cmd_type   cmd_in;
   cmd_type   cmd_ff;
   logic      busy_ff;
   logic      launch_ff;
   cnt_type   counts_ff [PIN_COUNT];
   beat_type  beats [EVENTS_PER_PIN+1];
   entry_type rd_entry [EVENTS_PER_PIN+1];
   logic [EVENTS_PER_PIN:0] act_vec;
   beat_type  last;
   logic      done;
   logic [1:0] status_in;
   cnt_type   cnt_in;
   cnt_type   idx_in;
   logic [7:0] lvl_in;
   logic       rsp_valid_ff;
   logic [1:0] rsp_status_ff;
   logic [4:0] rsp_next_index_ff;
   logic [4:0] rsp_entry_count_ff;
   logic [7:0] rsp_next_level_ff;

   assign accept = start && !busy_ff;
   assign pin_ok = int'(req_pin_index) < PIN_COUNT;
   assign n_sel  = pin_ok ? counts_ff[PIN_W'(req_pin_index)] : '0;

   always_comb begin
      cmd_in.func          = func_type'(req_func);
      cmd_in.pin           = PIN_W'(req_pin_index);
      cmd_in.pin_ok        = pin_ok;
      cmd_in.ins_ok        = pin_ok && (n_sel < CNT_W'(EVENTS_PER_PIN));
      cmd_in.count         = n_sel;
      cmd_in.key           = time_key(req_hour, req_minute);
      cmd_in.now_date      = date_key(req_now_month, req_now_day);
      cmd_in.ev.hour       = req_hour;
      cmd_in.ev.minute     = req_minute;
      cmd_in.ev.from_month = req_from_month;
      cmd_in.ev.from_day   = req_from_day;
      cmd_in.ev.to_month   = req_to_month;
      cmd_in.ev.to_day     = req_to_day;
      cmd_in.ev.level      = req_level;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_ff <= '0;
      end else if (accept) begin
         cmd_ff <= cmd_in;
      end
   end

   assign beats[0] = '{act: launch_ff, flag: 1'b0, idx: '0, lvl: '0, carry: cmd_ff.ev};
   assign rd_entry[EVENTS_PER_PIN] = '0;

   for (genvar g = 0; g < EVENTS_PER_PIN; g++) begin : g_cell
      stst_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cell_idx    (CNT_W'(g)),
         .cmd         (cmd_ff),
         .beat_in     (beats[g]),
         .beat_out    (beats[g+1]),
         .right_entry (rd_entry[g+1]),
         .own_entry   (rd_entry[g])
      );
   end

   for (genvar a = 0; a <= EVENTS_PER_PIN; a++) begin : g_act
      assign act_vec[a] = beats[a].act;
   end

   assign last = beats[EVENTS_PER_PIN];
   assign done = last.act;

   always_comb begin
      status_in = STATUS_OK;
      cnt_in    = cmd_ff.count;
      idx_in    = '0;
      lvl_in    = '0;
      unique case (cmd_ff.func)
         FUNC_INSERT: begin
            if (cmd_ff.ins_ok) begin
               cnt_in = cmd_ff.count + CNT_W'(1);
            end else begin
               status_in = STATUS_FULL;
            end
         end
         FUNC_REMOVE: begin
            if (last.flag) begin
               cnt_in = cmd_ff.count - CNT_W'(1);
            end else begin
               status_in = STATUS_MISS;
            end
         end
         FUNC_CLEAR: begin
            cnt_in = '0;
         end
         FUNC_QUERY: begin
            idx_in = last.flag ? last.idx : cmd_ff.count;
            lvl_in = last.flag ? last.lvl : 8'd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         launch_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int p = 0; p < PIN_COUNT; p++) begin
            counts_ff[p] <= '0;
         end
      end else begin
         launch_ff    <= accept;
         rsp_valid_ff <= done;
         if (accept) begin
            busy_ff <= 1'b1;
         end else if (done) begin
            busy_ff <= 1'b0;
         end
         if (done && cmd_ff.pin_ok) begin
            counts_ff[cmd_ff.pin] <= cnt_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         rsp_status_ff      <= status_in;
         rsp_next_index_ff  <= 5'(idx_in);
         rsp_entry_count_ff <= 5'(cnt_in);
         rsp_next_level_ff  <= lvl_in;
      end
   end

   assign busy            = busy_ff;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_next_index  = rsp_next_index_ff;
   assign rsp_entry_count = rsp_entry_count_ff;
   assign rsp_next_level  = rsp_next_level_ff;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy && !rsp_valid)
      else $error("busy did not rise after a command beat");

   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy_ff))
      else $error("result strobe without a command in flight");

   a_single_beat: assert property (@(posedge clock) disable iff (reset)
      $onehot0(act_vec))
      else $error("more than one command beat in the cell chain");

   a_full_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == STATUS_FULL)) |->
         (rsp_next_index == 5'd0) && (rsp_next_level == 8'd0))
      else $error("dropped insert reported query fields");

endmodule

>>> dv/stst_schedule_checker.sv
`timescale 1ns / 1ps
// Checker for the sorted time schedule table: watches the command and result channels,
// predicts each result from its own copy of the per-pin tables and counts mismatches.
// Depends on stst_pkg for the entry type, the command codes and the status codes.
module stst_schedule_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic       busy,
   input  logic [1:0] req_func,
   input  logic [2:0] req_pin_index,
   input  logic [4:0] req_hour,
   input  logic [5:0] req_minute,
   input  logic [3:0] req_from_month,
   input  logic [4:0] req_from_day,
   input  logic [3:0] req_to_month,
   input  logic [4:0] req_to_day,
   input  logic [7:0] req_level,
   input  logic [3:0] req_now_month,
   input  logic [4:0] req_now_day,
   input  logic       rsp_valid,
   input  logic [1:0] rsp_status,
   input  logic [4:0] rsp_next_index,
   input  logic [4:0] rsp_entry_count,
   input  logic [7:0] rsp_next_level,
   output int         fail_count,
   output int         pending_count
);
   import stst_pkg::*;

   typedef struct packed {
      logic [1:0] status;
      logic [4:0] next_index;
      logic [4:0] entry_count;
      logic [7:0] next_level;
   } sched_rsp_type;

   entry_type     pin_table [PIN_COUNT][EVENTS_PER_PIN];
   int unsigned   pin_fill [PIN_COUNT];
   sched_rsp_type expected_rsp_q [$];
   sched_rsp_type oldest_rsp;
   entry_type     cmd_event;
   int            mismatches = 0;
   int            outstanding = 0;

   assign fail_count    = mismatches;
   assign pending_count = outstanding;

   function automatic int unsigned minute_of_day(input logic [4:0] hour, input logic [5:0] minute);
      return hour * 60 + minute;
   endfunction

   function automatic sched_rsp_type predict_schedule_op(input func_type func,
                                                         input int unsigned pin,
                                                         input entry_type ev,
                                                         input logic [3:0] now_month,
                                                         input logic [4:0] now_day);
      sched_rsp_type r;
      entry_type     e;
      int unsigned   n;
      int unsigned   pos;
      int unsigned   now_key;
      int unsigned   today;
      bit            found;
      r = '0;
      if (pin >= PIN_COUNT) begin
         if (func == FUNC_INSERT) begin
            r.status = STATUS_FULL;
         end else if (func == FUNC_REMOVE) begin
            r.status = STATUS_MISS;
         end
         return r;
      end
      n = pin_fill[pin];
      found = 0;
      case (func)
         FUNC_INSERT: begin
            if (n >= EVENTS_PER_PIN) begin
               r.status = STATUS_FULL;
            end else begin
               pos = n;
               while (pos > 0 &&
                      minute_of_day(pin_table[pin][pos-1].hour, pin_table[pin][pos-1].minute)
                      > minute_of_day(ev.hour, ev.minute))
                  pos--;
               for (int i = n; i > pos; i--)
                  pin_table[pin][i] = pin_table[pin][i-1];
               pin_table[pin][pos] = ev;
               n++;
            end
         end
         FUNC_REMOVE: begin
            r.status = STATUS_MISS;
            for (int i = 0; i < n && !found; i++) begin
               if (pin_table[pin][i] == ev) begin
                  found = 1;
                  for (int j = i; j < n - 1; j++)
                     pin_table[pin][j] = pin_table[pin][j+1];
               end
            end
            if (found) begin
               n--;
               r.status = STATUS_OK;
            end
         end
         FUNC_CLEAR: begin
            n = 0;
         end
         default: begin
            now_key = minute_of_day(ev.hour, ev.minute);
            today = now_month * 32 + now_day;
            r.next_index = 5'(n);
            for (int i = 0; i < n && !found; i++) begin
               e = pin_table[pin][i];
               if (minute_of_day(e.hour, e.minute) >= now_key &&
                   today >= e.from_month * 32 + e.from_day &&
                   today <= e.to_month * 32 + e.to_day) begin
                  found = 1;
                  r.next_index = 5'(i);
                  r.next_level = e.level;
               end
            end
         end
      endcase
      pin_fill[pin] = n;
      r.entry_count = 5'(n);
      return r;
   endfunction

   function automatic void check_field(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset === 1'b1) begin
         for (int p = 0; p < PIN_COUNT; p++)
            pin_fill[p] = 0;
         expected_rsp_q.delete();
      end else begin
         if (rsp_valid === 1'b1) begin
            if (expected_rsp_q.size() == 0) begin
               $error("unexpected result beat: status %0d, next_index %0d, entry_count %0d",
                      rsp_status, rsp_next_index, rsp_entry_count);
               mismatches++;
            end else begin
               oldest_rsp = expected_rsp_q.pop_front();
               check_field("status", 8'(oldest_rsp.status), 8'(rsp_status));
               check_field("next_index", 8'(oldest_rsp.next_index), 8'(rsp_next_index));
               check_field("entry_count", 8'(oldest_rsp.entry_count), 8'(rsp_entry_count));
               check_field("next_level", oldest_rsp.next_level, rsp_next_level);
            end
         end
         if (start === 1'b1 && busy === 1'b0) begin
            cmd_event = '{hour: req_hour, minute: req_minute, from_month: req_from_month,
                          from_day: req_from_day, to_month: req_to_month, to_day: req_to_day,
                          level: req_level};
            expected_rsp_q.push_back(predict_schedule_op(func_type'(req_func), req_pin_index,
                                                         cmd_event, req_now_month, req_now_day));
         end
      end
      outstanding = expected_rsp_q.size();
   end

endmodule

>>> dv/sorted_time_schedule_table_top_tb.sv
`timescale 1ns / 1ps
// Testbench top for the sorted time schedule table: clock, reset, directed and random commands.
// Depends on stst_pkg, sorted_time_schedule_table_top and stst_schedule_checker.
module sorted_time_schedule_table_top_tb;
   import stst_pkg::*;

   typedef struct {
      func_type   func;
      logic [2:0] pin;
      logic [4:0] hour;
      logic [5:0] minute;
      logic [3:0] from_month;
      logic [4:0] from_day;
      logic [3:0] to_month;
      logic [4:0] to_day;
      logic [7:0] level;
      logic [3:0] now_month;
      logic [4:0] now_day;
   } sched_req_type;

   logic       clock;
   logic       reset;
   logic       start;
   logic       busy;
   logic [1:0] req_func;
   logic [2:0] req_pin_index;
   logic [4:0] req_hour;
   logic [5:0] req_minute;
   logic [3:0] req_from_month;
   logic [4:0] req_from_day;
   logic [3:0] req_to_month;
   logic [4:0] req_to_day;
   logic [7:0] req_level;
   logic [3:0] req_now_month;
   logic [4:0] req_now_day;
   logic       rsp_valid;
   logic [1:0] rsp_status;
   logic [4:0] rsp_next_index;
   logic [4:0] rsp_entry_count;
   logic [7:0] rsp_next_level;
   int         fail_count;
   int         pending_count;

   int            idle_pct;
   logic [2:0]    hot_pin;
   sched_req_type inserted_log [$];

   sorted_time_schedule_table_top dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_func(req_func), .req_pin_index(req_pin_index), .req_hour(req_hour),
      .req_minute(req_minute), .req_from_month(req_from_month), .req_from_day(req_from_day),
      .req_to_month(req_to_month), .req_to_day(req_to_day), .req_level(req_level),
      .req_now_month(req_now_month), .req_now_day(req_now_day),
      .rsp_valid(rsp_valid), .rsp_status(rsp_status), .rsp_next_index(rsp_next_index),
      .rsp_entry_count(rsp_entry_count), .rsp_next_level(rsp_next_level)
   );

   stst_schedule_checker schedule_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_func(req_func), .req_pin_index(req_pin_index), .req_hour(req_hour),
      .req_minute(req_minute), .req_from_month(req_from_month), .req_from_day(req_from_day),
      .req_to_month(req_to_month), .req_to_day(req_to_day), .req_level(req_level),
      .req_now_month(req_now_month), .req_now_day(req_now_day),
      .rsp_valid(rsp_valid), .rsp_status(rsp_status), .rsp_next_index(rsp_next_index),
      .rsp_entry_count(rsp_entry_count), .rsp_next_level(rsp_next_level),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("sorted_time_schedule_table_top verification failed");
      $finish;
   end

   function automatic sched_req_type make_cmd(input func_type func, input int pin,
                                              input int hour, input int minute,
                                              input int fm, input int fd,
                                              input int tm, input int td, input int level,
                                              input int nm, input int nd);
      sched_req_type c;
      c.func = func;
      c.pin = 3'(pin);
      c.hour = 5'(hour);
      c.minute = 6'(minute);
      c.from_month = 4'(fm);
      c.from_day = 5'(fd);
      c.to_month = 4'(tm);
      c.to_day = 5'(td);
      c.level = 8'(level);
      c.now_month = 4'(nm);
      c.now_day = 5'(nd);
      return c;
   endfunction

   function automatic int unsigned pick(input int unsigned lo, input int unsigned hi, input int w);
      if ($urandom_range(0, 9) == 0)
         return $urandom_range(0, (1 << w) - 1);
      return $urandom_range(lo, hi);
   endfunction

   function automatic sched_req_type random_command();
      sched_req_type c;
      int unsigned   sel;
      int unsigned   open_month;
      sel = $urandom_range(0, 99);
      open_month = pick(1, 12, 4);
      c.pin = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : hot_pin;
      c.hour = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 1)) : 5'(pick(0, 23, 5));
      c.minute = 6'(pick(0, 59, 6));
      c.from_month = 4'(open_month);
      c.from_day = 5'(pick(1, 31, 5));
      c.to_month = ($urandom_range(0, 9) < 7) ? 4'($urandom_range(open_month, 12))
                                              : 4'(pick(1, 12, 4));
      c.to_day = 5'(pick(1, 31, 5));
      c.level = 8'($urandom_range(0, 255));
      c.now_month = 4'(pick(1, 12, 4));
      c.now_day = 5'(pick(1, 31, 5));
      if (sel < 50) begin
         c.func = FUNC_INSERT;
         inserted_log.push_back(c);
         if (inserted_log.size() > 64)
            void'(inserted_log.pop_front());
      end else if (sel < 65) begin
         if (inserted_log.size() > 0 && $urandom_range(0, 9) < 8) begin
            c = inserted_log[$urandom_range(0, inserted_log.size() - 1)];
            if ($urandom_range(0, 9) == 0)
               c.level = c.level ^ 8'h01;
         end
         c.func = FUNC_REMOVE;
      end else if (sel < 67) begin
         c.func = FUNC_CLEAR;
      end else begin
         c.func = FUNC_QUERY;
         if ($urandom_range(0, 1) == 0) begin
            c.hour = '0;
            c.minute = '0;
         end
      end
      return c;
   endfunction

   task automatic send_command(input sched_req_type c);
      int gap;
      gap = 0;
      while ($urandom_range(0, 99) < idle_pct)
         gap++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_func <= c.func;
      req_pin_index <= c.pin;
      req_hour <= c.hour;
      req_minute <= c.minute;
      req_from_month <= c.from_month;
      req_from_day <= c.from_day;
      req_to_month <= c.to_month;
      req_to_day <= c.to_day;
      req_level <= c.level;
      req_now_month <= c.now_month;
      req_now_day <= c.now_day;
      do
         @(posedge clock);
      while (busy !== 1'b0);
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_func = '0;
      req_pin_index = '0;
      req_hour = '0;
      req_minute = '0;
      req_from_month = '0;
      req_from_day = '0;
      req_to_month = '0;
      req_to_day = '0;
      req_level = '0;
      req_now_month = '0;
      req_now_day = '0;
      idle_pct = 8;
      hot_pin = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      send_command(make_cmd(FUNC_INSERT, 0, 12, 30, 1, 1, 12, 31, 8'h11, 1, 1));
      send_command(make_cmd(FUNC_INSERT, 0, 12, 30, 1, 1, 12, 31, 8'h22, 1, 1));
      send_command(make_cmd(FUNC_INSERT, 0, 0, 0, 1, 1, 1, 1, 8'h00, 1, 1));
      send_command(make_cmd(FUNC_INSERT, 0, 31, 63, 15, 31, 15, 31, 8'hFF, 15, 31));
      send_command(make_cmd(FUNC_INSERT, 0, 23, 59, 0, 0, 0, 0, 8'hAA, 0, 0));
      send_command(make_cmd(FUNC_INSERT, 0, 1, 0, 6, 1, 6, 30, 8'h31, 1, 1));
      send_command(make_cmd(FUNC_INSERT, 0, 0, 60, 6, 1, 6, 30, 8'h32, 1, 1));
      send_command(make_cmd(FUNC_QUERY, 0, 12, 30, 0, 0, 0, 0, 0, 6, 15));
      send_command(make_cmd(FUNC_QUERY, 0, 0, 0, 15, 31, 15, 31, 8'hFF, 1, 1));
      send_command(make_cmd(FUNC_QUERY, 0, 0, 30, 0, 0, 0, 0, 0, 6, 10));
      send_command(make_cmd(FUNC_QUERY, 0, 31, 63, 0, 0, 0, 0, 0, 15, 31));
      send_command(make_cmd(FUNC_QUERY, 0, 31, 63, 0, 0, 0, 0, 0, 1, 1));
      send_command(make_cmd(FUNC_REMOVE, 0, 12, 30, 1, 1, 12, 31, 8'h22, 0, 0));
      send_command(make_cmd(FUNC_REMOVE, 0, 12, 30, 1, 1, 12, 31, 8'h33, 0, 0));
      send_command(make_cmd(FUNC_QUERY, 0, 12, 0, 0, 0, 0, 0, 0, 6, 15));
      send_command(make_cmd(FUNC_QUERY, 7, 0, 0, 0, 0, 0, 0, 0, 1, 1));
      send_command(make_cmd(FUNC_REMOVE, 7, 0, 0, 1, 1, 1, 1, 0, 0, 0));
      send_command(make_cmd(FUNC_CLEAR, 0, 31, 63, 15, 31, 15, 31, 8'hFF, 15, 31));
      send_command(make_cmd(FUNC_QUERY, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1));
      send_command(make_cmd(FUNC_INSERT, 7, 31, 63, 15, 31, 15, 31, 8'hFF, 15, 31));
      send_command(make_cmd(FUNC_QUERY, 7, 31, 63, 0, 0, 0, 0, 0, 15, 31));
      send_command(make_cmd(FUNC_CLEAR, 7, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      send_command(make_cmd(FUNC_CLEAR, 3, 0, 0, 0, 0, 0, 0, 0, 0, 0));

      for (int phase = 0; phase < 3; phase++) begin
         idle_pct = (phase == 0) ? 8 : (phase == 1) ? 82 : 0;
         for (int n = 0; n < 317; n++) begin
            if (n % 100 == 0)
               hot_pin = 3'($urandom_range(0, 7));
            send_command(random_command());
         end
      end
      start <= 1'b0;

      do
         @(posedge clock);
      while (pending_count != 0);
      repeat (40) @(posedge clock);

      if (fail_count == 0 && pending_count == 0) begin
         $display("sorted_time_schedule_table_top verification clean");
      end else begin
         $display("sorted_time_schedule_table_top verification failed");
      end
      $finish;
   end

endmodule

>>> files.f
hw/rtl/stst_pkg.sv
hw/rtl/stst_cell.sv
hw/rtl/sorted_time_schedule_table_top.sv
dv/stst_schedule_checker.sv
dv/sorted_time_schedule_table_top_tb.sv
